@@ rtl/mvavg_pkg.sv @@
// shared constants and types for the moving average with warm-up
// no dependencies; imported by mvavg_div and the top level

package mvavg_pkg;

    // sample and average width
    localparam int SAMPLE_W  = 32;
    // default ring depth
    localparam int DEPTH_DEF = 16;

    // request from the sequencer to the divider
    typedef struct packed {
        logic start;
        logic neg;
    } div_req_t;

    // status from the divider back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/mvavg_ram.sv @@
// generic single-port ram with registered read data
// depends on no package

module mvavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mvavg_div.sv @@
// restoring divider, one quotient bit per cycle, sign applied at the end
// depends on mvavg_pkg

module mvavg_div
    import mvavg_pkg::*;
#(
    parameter int SUM_W = 36,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [SUM_W-1:0] dividend,   // magnitude of the running sum
    input  logic [CNT_W-1:0] divisor,    // sample count, never zero
    output div_stat_t        stat,
    output logic [SAMPLE_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    dvs_reg, dvs_next;
    logic [SAMPLE_W-1:0] res_reg, res_next;

    logic [CNT_W:0]      shifted;
    logic [CNT_W:0]      diff;
    logic                fits;
    logic [SUM_W-1:0]    quo_step;

    // one trial subtraction
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[SUM_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = (shifted >= {1'b0, dvs_reg});
        quo_step = {quo_reg[SUM_W-2:0], fits};
    end

    // iteration control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        res_next  = res_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.neg;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = quo_step;
            rem_next = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (~quo_step[SAMPLE_W-1:0] + SAMPLE_W'(1))
                                    : quo_step[SAMPLE_W-1:0];
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        res_reg <= res_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = res_reg;

endmodule

@@ rtl/moving_average_with_warmup_unit.sv @@
// top level of the moving average with warm-up: sequencer, ring and running sum
// depends on mvavg_pkg, mvavg_ram and mvavg_div

// Each accepted item is one signed 32-bit sample. It replaces the oldest of the
// last DEPTH samples in a ring, and the block returns the sum of the samples held
// divided by their count (1 to DEPTH while warming up, DEPTH after), truncated
// toward zero. The running sum is SUM_W = 32 + clog2(DEPTH) bits wide, and the
// restoring divider produces one quotient bit per cycle. s_tready is high
// only while no item is in work; a finished result waits in the output register.

module moving_average_with_warmup_unit
    import mvavg_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata    // [31:0] average
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + PTR_W;
    localparam int EXT_W = SUM_W - SAMPLE_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_HOLD   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      wptr_reg, wptr_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [SAMPLE_W-1:0]   avg_reg, avg_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  full;
    logic [SAMPLE_W-1:0]   old_sample;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic [SUM_W-1:0]      sum_upd;
    logic [SUM_W-1:0]      sum_mag;
    logic [CNT_W-1:0]      fill_upd;
    div_req_t              div_req;
    div_stat_t             div_stat;
    logic [SAMPLE_W-1:0]   div_quo;
    logic                  out_free;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign out_free = !out_valid_reg || m_tready;

    // sample ring
    mvavg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH),
        .ADDR_W(PTR_W)
    ) u_ring (
        .clk  (clk),
        .we   (state_reg == S_UPDATE),
        .re   (state_reg == S_READ),
        .addr (wptr_reg),
        .wdata(sample_reg),
        .rdata(ram_rdata)
    );

    // running sum update: drop the overwritten sample once the ring is full
    always_comb
    begin
        old_sample = full ? ram_rdata : '0;
        sum_upd    = sum_reg
                   - {{EXT_W{old_sample[SAMPLE_W-1]}}, old_sample}
                   + {{EXT_W{sample_reg[SAMPLE_W-1]}}, sample_reg};
        sum_mag    = sum_upd[SUM_W-1] ? (~sum_upd + SUM_W'(1)) : sum_upd;
        fill_upd   = full ? fill_reg : fill_reg + CNT_W'(1);
    end

    // divider
    mvavg_div #(
        .SUM_W(SUM_W),
        .CNT_W(CNT_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .dividend(sum_mag),
        .divisor (fill_upd),
        .stat    (div_stat),
        .quotient(div_quo)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg;
        div_req.start  = 1'b0;
        div_req.neg    = sum_upd[SUM_W-1];
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    sample_next = s_tdata;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                sum_next      = sum_upd;
                fill_next     = fill_upd;
                wptr_next     = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wptr_reg + PTR_W'(1);
                div_req.start = 1'b1;
                state_next    = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    avg_next       = div_quo;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wptr_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        avg_reg    <= avg_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = avg_reg;

    // fill count never passes the ring depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // during warm-up the write pointer tracks the fill count
    a_warmup_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (CNT_W'(wptr_reg) == fill_reg))
        else $error("write pointer out of step with fill count");

    // divider is idle whenever a new item can be taken
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIVIDE))
        else $error("divider done outside divide state");

endmodule
